// ===== rtl/ktacc_pkg.sv =====
// Shared types, sizes and helper functions for the keyed total accumulator.
// Used by ktacc_cell and keyed_total_accumulator; depends on nothing else.
`default_nettype none

package ktacc_pkg;

	localparam int ENTRIES    = 16;
	localparam int NAME_BYTES = 11;
	localparam int KEY_BYTES  = 11;
	localparam int KEY_W      = 8 * KEY_BYTES;
	localparam int HEAD_W     = 64;
	localparam int TAIL_W     = 24;
	localparam int PTS_W      = 16;
	localparam int TOT_W      = 32;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int SLOT_OUT_W = 4;
	localparam int CNT_OUT_W  = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Record that walks down the cell chain with one item.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TOT_W-1:0] pts;
		logic             done;
		logic             is_new;
		idx_t             slot;
		logic [TOT_W-1:0] total;
		logic             lead_any;
		idx_t             lead_slot;
		logic [TOT_W-1:0] lead_total;
	} rec_t;

	// A name ends at its first NUL byte or after NAME_BYTES bytes; all bytes
	// from there on are forced to zero so they never affect matching.
	function automatic logic [KEY_W-1:0] canon_key(input logic [HEAD_W-1:0] head,
			input logic [TAIL_W-1:0] tail);
		logic [KEY_W-1:0] raw;
		logic [KEY_W-1:0] key;
		logic             ended;
		raw   = {head, tail};
		key   = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (i >= NAME_BYTES || raw[KEY_W-1-8*i -: 8] == 8'h00) begin
				ended = 1'b1;
			end
			if (!ended) begin
				key[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
			end
		end
		return key;
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] slot_out(input idx_t idx);
		logic [IDX_W+SLOT_OUT_W-1:0] wide;
		wide = {{SLOT_OUT_W{1'b0}}, idx};
		return wide[SLOT_OUT_W-1:0];
	endfunction

	function automatic logic [CNT_OUT_W-1:0] cnt_out(input cnt_t cnt);
		logic [CNT_W+CNT_OUT_W-1:0] wide;
		wide = {{CNT_OUT_W{1'b0}}, cnt};
		return wide[CNT_OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ktacc_cell.sv =====
// One table entry of the keyed total accumulator: stored key, total and valid bit.
// Updates its entry and the running leader in the record passing through it.
// Depends on ktacc_pkg.
`default_nettype none

module ktacc_cell import ktacc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire idx_t cell_idx,
	input  wire logic rec_vld_in,
	input  wire rec_t rec_in,
	output logic      rec_vld_out,
	output rec_t      rec_out
);

	logic [KEY_W-1:0] key_q;
	logic [TOT_W-1:0] total_q;
	logic             used_q;
	logic             rec_vld_q;
	rec_t             rec_q;

	logic             open;
	logic             hit;
	logic             alloc;
	logic [TOT_W-1:0] new_total;
	logic             new_used;
	rec_t             rec_nxt;

	// Keys are unique among used entries, so at most one cell can hit.
	// Entries fill in order, so the first unused cell reached is the free one.
	assign open      = rec_vld_in && !rec_in.done;
	assign hit       = open && used_q && (key_q == rec_in.key);
	assign alloc     = open && !used_q;
	assign new_used  = used_q || alloc;
	assign new_total = hit ? (total_q + rec_in.pts) : (alloc ? rec_in.pts : total_q);

	always_comb begin
		rec_nxt = rec_in;
		if (hit || alloc) begin
			rec_nxt.done   = 1'b1;
			rec_nxt.is_new = alloc;
			rec_nxt.slot   = cell_idx;
			rec_nxt.total  = new_total;
		end
		// Cells behind the touched one still hold their old totals, and the
		// touched cell compares its new total, so one pass gives the argmax.
		if (new_used && (!rec_in.lead_any ||
				$signed(new_total) > $signed(rec_in.lead_total))) begin
			rec_nxt.lead_any   = 1'b1;
			rec_nxt.lead_slot  = cell_idx;
			rec_nxt.lead_total = new_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			rec_vld_q <= 1'b0;
		end else if (advance) begin
			rec_vld_q <= rec_vld_in;
			if (alloc) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_q <= rec_nxt;
			if (alloc) begin
				key_q <= rec_in.key;
			end
			if (hit || alloc) begin
				total_q <= new_total;
			end
		end
	end

	assign rec_vld_out = rec_vld_q;
	assign rec_out     = rec_q;

endmodule

`default_nettype wire

// ===== rtl/keyed_total_accumulator.sv =====
// Top level of the keyed total accumulator: input front end, cell chain and
// output register. Depends on ktacc_pkg and ktacc_cell.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    name_head, name_tail, points
//   output    out_valid / out_stall  slot, is_new, dropped, entry_total,
//                                    entry_count, leader_slot, leader_total
//
// An item walks the chain of ENTRIES cells, one cell per cycle, and lands in
// the output register. One item is in the chain at a time; the next
// input transfer is taken in the cycle after the result reaches the
// output register.
// Reset empties the table at once; there is no clearing pass.
// A stalled output holds the finished item at the end of the chain.
`default_nettype none

module keyed_total_accumulator import ktacc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [HEAD_W-1:0]     name_head,
	input  wire logic [TAIL_W-1:0]     name_tail,
	input  wire logic signed [PTS_W-1:0] points,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [SLOT_OUT_W-1:0]      slot,
	output logic                       is_new,
	output logic                       dropped,
	output logic signed [TOT_W-1:0]    entry_total,
	output logic [CNT_OUT_W-1:0]       entry_count,
	output logic [SLOT_OUT_W-1:0]      leader_slot,
	output logic signed [TOT_W-1:0]    leader_total
);

	logic busy_q;
	logic out_valid_q;
	cnt_t count_q;

	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  is_new_q;
	logic                  dropped_q;
	logic [TOT_W-1:0]      entry_total_q;
	logic [SLOT_OUT_W-1:0] leader_slot_q;
	logic [TOT_W-1:0]      leader_total_q;

	logic in_xfer;
	logic advance;
	logic load_out;
	rec_t front;
	logic vld_chain [ENTRIES+1];
	rec_t rec_chain [ENTRIES+1];
	rec_t last;

	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;

	always_comb begin
		front            = '0;
		front.key        = canon_key(name_head, name_tail);
		front.pts        = {{(TOT_W-PTS_W){points[PTS_W-1]}}, points};
	end

	assign vld_chain[0] = in_xfer;
	assign rec_chain[0] = front;

	// Only the finished item can be held back; the rest of the chain is empty.
	assign last     = rec_chain[ENTRIES];
	assign load_out = vld_chain[ENTRIES] && (!out_valid_q || !out_stall);
	assign advance  = !(vld_chain[ENTRIES] && out_valid_q && out_stall);

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ktacc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.advance     (advance),
			.cell_idx    (IDX_W'(g)),
			.rec_vld_in  (vld_chain[g]),
			.rec_in      (rec_chain[g]),
			.rec_vld_out (vld_chain[g+1]),
			.rec_out     (rec_chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (last.is_new) begin
					count_q <= count_q + cnt_t'(1);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slot_q         <= slot_out(last.slot);
			is_new_q       <= last.is_new;
			dropped_q      <= !last.done;
			entry_total_q  <= last.total;
			leader_slot_q  <= slot_out(last.lead_slot);
			leader_total_q <= last.lead_total;
		end
	end

	assign out_valid    = out_valid_q;
	assign slot         = slot_q;
	assign is_new       = is_new_q;
	assign dropped      = dropped_q;
	assign entry_total  = entry_total_q;
	assign entry_count  = cnt_out(count_q);
	assign leader_slot  = leader_slot_q;
	assign leader_total = leader_total_q;

endmodule

`default_nettype wire
